[design/isfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfe_pkg
// Shared types, constants and the crc helper of the imu sample frame encoder.
// ----------------------------------------------------------------------------
package isfe_pkg;

	// frame layout
	localparam int FRAME_BYTES   = 31;
	localparam int PAYLOAD_BYTES = 24;
	localparam int HDR_BYTES     = 5;
	localparam int POS_W         = $clog2(FRAME_BYTES);

	localparam logic [POS_W-1:0] POS_MAGIC_FIRST  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_MAGIC_SECOND = POS_W'(1);
	localparam logic [POS_W-1:0] POS_TYPE         = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LEN_LO       = POS_W'(3);
	localparam logic [POS_W-1:0] POS_LEN_HI       = POS_W'(4);
	localparam logic [POS_W-1:0] POS_PAY_FIRST    = POS_W'(HDR_BYTES);
	localparam logic [POS_W-1:0] POS_PAY_LAST     = POS_W'(HDR_BYTES + PAYLOAD_BYTES - 1);
	localparam logic [POS_W-1:0] POS_CRC_LO       = POS_W'(HDR_BYTES + PAYLOAD_BYTES);
	localparam logic [POS_W-1:0] POS_CRC_HI       = POS_W'(FRAME_BYTES - 1);

	localparam logic [15:0] LEN_FIELD_VALUE = 16'(PAYLOAD_BYTES);
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;

	// default depth of the sample queue
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAGIC_FIRST  = 2'd0,
		REG_MAGIC_SECOND = 2'd1,
		REG_FRAME_TYPE   = 2'd2
	} cfg_reg_t;

	// one input word: an imu sample
	typedef struct packed {
		logic signed [31:0] time_us;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic signed [15:0] temperature;
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
		logic signed [15:0] mag_z;
	} sample_t;

	// one output word: a frame byte
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} result_t;

	// header bytes held in configuration registers
	typedef struct packed {
		logic [7:0] magic_first;
		logic [7:0] magic_second;
		logic [7:0] frame_type;
	} hdr_cfg_t;

	// queue head handed to the serializer
	typedef struct packed {
		logic    valid;
		sample_t sample;
	} head_t;

	// crc-16/modbus update over one byte, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
		logic [15:0] c;
		c = crc ^ {8'h00, v};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[design/imu_sample_frame_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_sample_frame_encoder_top
// Encodes imu samples into 31-byte frames with crc-16/modbus over the payload.
//
//   channel   handshake          payload
//   sample    push / full        sample_t, one imu sample per word
//   result    empty / pop        result_t, one frame byte per word
//   cfg       cfg_valid / ready  cfg_index, cfg_data (header byte registers)
//
// A frame is 31 bytes, one byte per cycle while pop keeps the single output
// word register drained; the next frame follows without a gap if a sample waits.
// The sample queue, two entries deep by default, takes new samples while a frame drains.
// Reset clears queue, frame position and output valid; config resets to 0.
// A stalled pop holds the output word and stops the serializer only.
// ----------------------------------------------------------------------------
module imu_sample_frame_encoder_top import isfe_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  sample_t              sample,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	hdr_cfg_t hdr_q;
	head_t    head;
	logic     take;

	assign cfg_ready = 1'b1;

	// header byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAGIC_FIRST:  hdr_q.magic_first  <= cfg_data;
				REG_MAGIC_SECOND: hdr_q.magic_second <= cfg_data;
				REG_FRAME_TYPE:   hdr_q.frame_type   <= cfg_data;
				default:          hdr_q <= hdr_q;
			endcase
		end
	end

	// sample queue
	isfe_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.sample (sample),
		.head   (head),
		.take   (take)
	);

	// frame serializer
	isfe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.take   (take),
		.hdr    (hdr_q),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

[design/isfe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfe_front
// Accepts samples and holds them in a short register queue for the serializer.
// ----------------------------------------------------------------------------
module isfe_front import isfe_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH // 2 or more
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  sample_t sample,
	output head_t   head,
	input  logic    take
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	sample_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;

	assign full    = (count_q == CNT_FULL);
	assign push_ok = push && !full;

	assign head.valid  = (count_q != '0);
	assign head.sample = mem_q[rd_ptr_q];

	// sample storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= sample;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_ok, take})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// checks
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> count_q != '0) else $error("take from empty sample queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL) else $error("sample queue count overflow");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok && !take |=> count_q == $past(count_q) + 1'b1)
		else $error("sample queue lost a push");

endmodule

[design/isfe_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfe_back
// Serializes the queue head into a 31-byte frame with running crc, one byte
// per cycle while the output is empty or popped, into a one-word output register.
// ----------------------------------------------------------------------------
module isfe_back import isfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  head_t    head,
	output logic     take,
	input  hdr_cfg_t hdr,
	output logic     empty,
	input  logic     pop,
	output result_t  result
);

	logic [POS_W-1:0]         pos_q;
	logic [15:0]              crc_q;
	logic                     out_valid_q;
	result_t                  out_q;
	logic                     produce;
	logic [7:0]               byte_sel;
	logic [8*PAYLOAD_BYTES-1:0] payload;
	logic [POS_W-1:0]         pay_idx;
	logic                     in_payload;

	// payload bytes, every field little-endian in input order
	assign payload = {head.sample.mag_z, head.sample.mag_y, head.sample.mag_x,
		head.sample.temperature, head.sample.gyro_z, head.sample.gyro_y,
		head.sample.gyro_x, head.sample.accel_z, head.sample.accel_y,
		head.sample.accel_x, head.sample.time_us};
	assign pay_idx    = pos_q - POS_PAY_FIRST;
	assign in_payload = (pos_q >= POS_PAY_FIRST) && (pos_q <= POS_PAY_LAST);

	// a byte moves into the output register when a sample is at the queue head and the register is free or being drained
	assign produce = head.valid && (!out_valid_q || pop);
	assign take    = produce && (pos_q == POS_CRC_HI);
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// byte select for the current frame position
	always_comb begin
		case (pos_q)
			POS_MAGIC_FIRST:  byte_sel = hdr.magic_first;
			POS_MAGIC_SECOND: byte_sel = hdr.magic_second;
			POS_TYPE:         byte_sel = hdr.frame_type;
			POS_LEN_LO:       byte_sel = LEN_FIELD_VALUE[7:0];
			POS_LEN_HI:       byte_sel = LEN_FIELD_VALUE[15:8];
			POS_CRC_LO:       byte_sel = crc_q[7:0];
			POS_CRC_HI:       byte_sel = crc_q[15:8];
			default:          byte_sel = payload[8*pay_idx +: 8];
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (produce) begin
			out_q.frame_byte <= byte_sel;
			out_q.last_byte  <= (pos_q == POS_CRC_HI);
		end
	end

	// frame position, running crc and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (produce) begin
				out_valid_q <= 1'b1;
				pos_q       <= (pos_q == POS_CRC_HI) ? '0 : pos_q + 1'b1;
				if (pos_q == POS_MAGIC_FIRST) begin
					crc_q <= CRC_INIT;
				end else if (in_payload) begin
					crc_q <= crc_byte(crc_q, byte_sel);
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_CRC_HI) else $error("frame position out of range");
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != POS_MAGIC_FIRST |-> head.valid) else $error("sample lost mid-frame");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		produce |=> out_q.last_byte == ($past(pos_q) == POS_CRC_HI))
		else $error("last byte flag misplaced");
	a_crc_start: assert property (@(posedge clk) disable iff (!arst_n)
		produce && pos_q == POS_MAGIC_FIRST |=> crc_q == CRC_INIT)
		else $error("crc not restarted at frame start");

endmodule
